>>> rtl/dmc_pkg.sv
// Shared types and constants of the demon Monte Carlo update block.
package dmc_pkg;

    localparam int VEL_W    = 24;
    localparam int MASS_W   = 16;
    localparam int ENERGY_W = 48;
    localparam int KE_W     = 37;
    localparam int INDEX_W  = 10;
    localparam int ENTRY_W  = MASS_W + VEL_W;

    // Pipeline depth of the kinetic energy unit.
    localparam int KE_LATENCY = 3;

    typedef logic signed [VEL_W-1:0] vel_t;
    typedef logic [MASS_W-1:0]       mass_t;
    typedef logic [ENERGY_W-1:0]     energy_t;
    typedef logic [KE_W-1:0]         ke_t;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_DEMON   = 2'd1,
        KIND_PERTURB = 2'd2
    } kind_t;

    localparam energy_t ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam vel_t    VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};
    localparam vel_t    VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};

endpackage

>>> rtl/dmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dmc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dmc_kinetic.sv
// Three-stage pipeline computing floor(m * v * v / 2^25), the kinetic energy in Q25.12.
module dmc_kinetic (
    input  logic          aclk,
    input  dmc_pkg::mass_t mass,
    input  dmc_pkg::vel_t  vel,
    output dmc_pkg::ke_t   ke
);
    import dmc_pkg::*;

    logic [VEL_W-1:0]     mag;
    logic [2*VEL_W-1:0]   sq_full;
    logic [2*VEL_W-2:0]   sq_reg;
    mass_t                m1_reg;
    logic [MASS_W+23:0]   plo_reg;
    logic [MASS_W+22:0]   phi_reg;
    logic [62:0]          full;
    ke_t                  ke_reg;

    // The magnitude of the most negative velocity is 2^23, which still fits unsigned.
    assign mag     = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
    assign sq_full = mag * mag;

    // The square is below 2^47, so it is split at bit 24 to keep each product narrow.
    assign full = {phi_reg, 24'b0} + {23'b0, plo_reg};

    always_ff @(posedge aclk) begin
        sq_reg  <= sq_full[2*VEL_W-2:0];
        m1_reg  <= mass;
        plo_reg <= m1_reg * sq_reg[23:0];
        phi_reg <= m1_reg * sq_reg[2*VEL_W-2:24];
        ke_reg  <= full[61:25];
    end

    assign ke = ke_reg;

endmodule

>>> rtl/demon_monte_carlo_update.sv
// Top level: Creutz demon Monte Carlo update over a particle memory.
//
// Input words arrive on the s_ channel: s_tuser carries the kind (load particle,
// set demon energy, perturb particle), s_tdata the index and operands. Every
// input word yields exactly one result word on the m_ channel: the accepted
// flag in m_tuser, the particle velocity, demon energy and kinetic sum in m_tdata.
// Velocity and mass of all particles sit in one synchronous RAM; the demon
// energy and kinetic sum are registers.
// An item passes from acceptance to its result in the output register through
// the memory read together with the trial velocity, the three stages of the
// kinetic energy multipliers and the commit. One item is in work at a time:
// the block returns to idle after the commit and takes the next word only
// there, so a new word waits until the last one has committed.
// After reset the block sweeps all NUM_PARTICLES entries of the particle memory to zero,
// one entry a cycle, with s_tready low; demon energy and kinetic sum reset to 0.
// If the receiver stalls, the result waits in the output register while the
// next word is taken and worked; that word then holds in its commit cycle,
// changing nothing, until the output register is free.
module demon_monte_carlo_update #(
    parameter int NUM_PARTICLES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] particle_index, [33:10] velocity_in, [49:34] mass_in,
    // [97:50] energy_in, [121:98] delta, [127:122] zero
    input  logic [127:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] velocity_out, [71:24] demon_energy_out, [119:72] kinetic_sum_out
    output logic [119:0] m_tdata,
    // [0] accepted
    output logic [0:0]   m_tuser
);
    import dmc_pkg::*;

    localparam int AW    = $clog2(NUM_PARTICLES);
    localparam int IDX_W = 17;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_COMMIT
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [1:0]      calc_cnt_reg;
    logic            m_tvalid_reg;
    energy_t         demon_reg;
    energy_t         ksum_reg;

    // Item and operand registers
    kind_t           kind_reg;
    logic [AW-1:0]   addr_reg;
    logic            valid_reg;
    vel_t            vin_reg;
    mass_t           min_reg;
    energy_t         ein_reg;
    vel_t            delta_reg;
    vel_t            v_old_reg;
    mass_t           m_old_reg;
    vel_t            vt_reg;
    vel_t            kn_v_reg;
    mass_t           kn_m_reg;

    // Output payload
    logic            acc_reg;
    vel_t            vout_reg;
    energy_t         eout_reg;
    energy_t         sout_reg;

    logic [IDX_W-1:0]   s_idx_ext;
    logic               s_valid_idx;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    vel_t               rd_vel;
    mass_t              rd_mass;
    logic signed [VEL_W:0] vt_sum;
    vel_t               vt_sat;
    ke_t                ke_old;
    ke_t                ke_new;
    logic [49:0]        et;
    logic [49:0]        sum_new;
    logic               perturb_ok;
    logic               out_free;
    logic               commit_fire;
    logic               commit_write;
    logic               acc_next;
    vel_t               vout_next;
    energy_t            demon_next;
    energy_t            ksum_next;

    function automatic energy_t clamp_energy(input logic [49:0] x);
        energy_t r;
        if (x[49]) begin
            r = '0;
        end else if (x[48]) begin
            r = ENERGY_MAX;
        end else begin
            r = x[ENERGY_W-1:0];
        end
        return r;
    endfunction

    assign s_idx_ext   = {{(IDX_W-INDEX_W){1'b0}}, s_tdata[INDEX_W-1:0]};
    assign s_valid_idx = s_idx_ext < IDX_W'(NUM_PARTICLES);

    assign rd_vel  = ram_rdata[VEL_W-1:0];
    assign rd_mass = ram_rdata[ENTRY_W-1:VEL_W];

    // Trial velocity with saturation to the Q11.12 range
    assign vt_sum = {rd_vel[VEL_W-1], rd_vel} + {delta_reg[VEL_W-1], delta_reg};
    always_comb begin
        if (vt_sum[VEL_W] != vt_sum[VEL_W-1]) begin
            vt_sat = vt_sum[VEL_W] ? VEL_MIN : VEL_MAX;
        end else begin
            vt_sat = vt_sum[VEL_W-1:0];
        end
    end

    dmc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_PARTICLES)
    ) u_particle_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s_idx_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    dmc_kinetic u_ke_old (
        .aclk (aclk),
        .mass (m_old_reg),
        .vel  (v_old_reg),
        .ke   (ke_old)
    );

    dmc_kinetic u_ke_new (
        .aclk (aclk),
        .mass (kn_m_reg),
        .vel  (kn_v_reg),
        .ke   (ke_new)
    );

    assign et      = {2'b0, demon_reg} + {13'b0, ke_old} - {13'b0, ke_new};
    assign sum_new = {2'b0, ksum_reg} - {13'b0, ke_old} + {13'b0, ke_new};
    assign perturb_ok = !et[49];

    assign out_free    = !m_tvalid_reg || m_tready;
    assign commit_fire = (state_reg == ST_COMMIT) && out_free;

    always_comb begin
        acc_next   = 1'b0;
        vout_next  = valid_reg ? v_old_reg : '0;
        demon_next = demon_reg;
        ksum_next  = ksum_reg;
        commit_write = 1'b0;
        case (kind_reg)
            KIND_LOAD: begin
                if (valid_reg) begin
                    ksum_next    = clamp_energy(sum_new);
                    acc_next     = 1'b1;
                    vout_next    = vin_reg;
                    commit_write = 1'b1;
                end
            end
            KIND_DEMON: begin
                demon_next = ein_reg;
                acc_next   = 1'b1;
            end
            KIND_PERTURB: begin
                if (valid_reg && perturb_ok) begin
                    demon_next   = clamp_energy(et);
                    ksum_next    = clamp_energy(sum_new);
                    acc_next     = 1'b1;
                    vout_next    = vt_reg;
                    commit_write = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = commit_fire && commit_write;
            ram_waddr = addr_reg;
            ram_wdata = (kind_reg == KIND_LOAD) ? {min_reg, vin_reg} : {m_old_reg, vt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            calc_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            demon_reg    <= '0;
            ksum_reg     <= '0;
        end else begin
            if (commit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(NUM_PARTICLES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    calc_cnt_reg <= '0;
                    state_reg    <= ST_CALC;
                end
                ST_CALC: begin
                    calc_cnt_reg <= calc_cnt_reg + 1'b1;
                    if (calc_cnt_reg == 2'(KE_LATENCY - 1)) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        demon_reg    <= demon_next;
                        ksum_reg     <= ksum_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= kind_t'(s_tuser);
            addr_reg  <= s_idx_ext[AW-1:0];
            valid_reg <= s_valid_idx;
            vin_reg   <= s_tdata[33:10];
            min_reg   <= s_tdata[49:34];
            ein_reg   <= s_tdata[97:50];
            delta_reg <= s_tdata[121:98];
        end
        if (state_reg == ST_READ) begin
            v_old_reg <= rd_vel;
            m_old_reg <= rd_mass;
            vt_reg    <= vt_sat;
            kn_v_reg  <= (kind_reg == KIND_LOAD) ? vin_reg : vt_sat;
            kn_m_reg  <= (kind_reg == KIND_LOAD) ? min_reg : rd_mass;
        end
        if (commit_fire) begin
            acc_reg  <= acc_next;
            vout_reg <= vout_next;
            eout_reg <= demon_next;
            sout_reg <= ksum_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sout_reg, eout_reg, vout_reg};
    assign m_tuser  = acc_reg;

    // A commit never writes a slot outside the particle range.
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != ST_CLEAR) |-> valid_reg)
        else $error("particle memory written for an out-of-range index");

    // A new result word only appears out of the commit cycle.
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_COMMIT)
        else $error("result word raised outside commit");

    // A rejected perturbation leaves demon energy and kinetic sum untouched.
    a_reject_keeps_energy: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_fire && kind_reg == KIND_PERTURB && !acc_next)
        |=> ($stable(demon_reg) && $stable(ksum_reg)))
        else $error("rejected perturbation changed the energies");

    // The energies move only when an item commits.
    a_energy_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR && $past(state_reg) != ST_CLEAR && !$past(commit_fire))
        |-> ($stable(demon_reg) && $stable(ksum_reg)))
        else $error("energy register changed outside commit");

endmodule
